// File: rtl/sgsd_pkg.sv
// Shared types and constants of the Shift-JIS glyph stream decoder.
package sgsd_pkg;

	// Depth of the command queue between front and back
	localparam int unsigned CmdDepth = 4;
	localparam int unsigned CmdPtrW  = $clog2(CmdDepth);
	localparam int unsigned CmdCntW  = $clog2(CmdDepth + 1);

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_LAYER   = 2'd0,
		CFG_START_X = 2'd1,
		CFG_ROW_Y   = 2'd2,
		CFG_COLOR   = 2'd3
	} cfg_idx_t;

	// Lead-byte conversion constants
	localparam logic [7:0] LeadSplit = 8'hA0;
	localparam logic [7:0] LeadOffLo = 8'h71;
	localparam logic [7:0] LeadOffHi = 8'hB1;
	localparam logic [7:0] TrailGap  = 8'h7F;
	localparam logic [7:0] TrailHigh = 8'h9E;
	localparam logic [7:0] TrailSubH = 8'h7D;
	localparam logic [7:0] TrailSubL = 8'h1F;
	localparam logic [7:0] JisBase   = 8'h21;
	localparam logic [6:0] RowCells  = 7'd94;

	// Cursor advance per glyph width
	localparam logic [31:0] StepFull = 32'd8;
	localparam logic [31:0] StepHalf = 32'd4;

	// Draw command handed from front to back
	typedef struct packed {
		logic [31:0] draw_x;
		logic [7:0]  lead;
		logic [7:0]  code;
		logic        full_width;
	} cmd_t;

endpackage

// File: rtl/sgsd_front.sv
// Front part: takes text bytes, tracks lead byte and cursor, issues draw commands.
module sgsd_front import sgsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        acc,
	input  logic [7:0]  text_byte,
	input  logic [31:0] start_x,
	output logic        cmd_valid,
	output cmd_t        cmd
);

	logic        lead_pending_q;
	logic [7:0]  held_lead_q;
	logic [31:0] cursor_q;
	logic        at_start_q;

	logic        is_zero;
	logic        is_lead;
	logic [31:0] cur_x;

	// Classify the byte and pick the cursor for this glyph
	always_comb begin
		is_zero = (text_byte == 8'h00);
		is_lead = ((text_byte > 8'h80) && (text_byte < 8'hA0)) ||
			((text_byte >= 8'hE0) && (text_byte < 8'hF0));
		cur_x   = at_start_q ? start_x : cursor_q;
	end

	// Form the command for a glyph-completing byte
	always_comb begin
		cmd_valid      = acc && !is_zero && (lead_pending_q || !is_lead);
		cmd.draw_x     = cur_x;
		cmd.lead       = held_lead_q;
		cmd.code       = text_byte;
		cmd.full_width = lead_pending_q;
	end

	// Advance string state per accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_pending_q <= 1'b0;
			held_lead_q    <= 8'h00;
			cursor_q       <= 32'd0;
			at_start_q     <= 1'b1;
		end else if (acc) begin
			if (is_zero) begin
				lead_pending_q <= 1'b0;
				held_lead_q    <= 8'h00;
				at_start_q     <= 1'b1;
			end else begin
				at_start_q <= 1'b0;
				if (lead_pending_q) begin
					lead_pending_q <= 1'b0;
					held_lead_q    <= 8'h00;
					cursor_q       <= cur_x + StepFull;
				end else if (is_lead) begin
					lead_pending_q <= 1'b1;
					held_lead_q    <= text_byte;
					cursor_q       <= cur_x;
				end else begin
					cursor_q <= cur_x + StepHalf;
				end
			end
		end
	end

endmodule

// File: rtl/sgsd_cmd_fifo.sv
// Short command queue between the front and back parts.
module sgsd_cmd_fifo import sgsd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_data,
	input  logic rd_en,
	output cmd_t rd_data,
	output logic full,
	output logic nonempty
);

	cmd_t               slots_q [CmdDepth];
	logic [CmdPtrW-1:0] wr_ptr_q;
	logic [CmdPtrW-1:0] rd_ptr_q;
	logic [CmdCntW-1:0] count_q;

	assign full     = (count_q == CmdCntW'(CmdDepth));
	assign nonempty = (count_q != '0);
	assign rd_data  = slots_q[rd_ptr_q];

	// Store a beat
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slots_q[wr_ptr_q] <= wr_data;
		end
	end

	// Move pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == CmdPtrW'(CmdDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == CmdPtrW'(CmdDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/sgsd_back.sv
// Back part: converts commands to glyph codes and holds the result register.
module sgsd_back import sgsd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cmd_avail,
	input  cmd_t         cmd,
	output logic         cmd_take,
	input  logic         pop,
	output logic         empty,
	output logic [31:0]  draw_x,
	output logic [15:0]  glyph_code,
	output logic         full_width
);

	logic        out_valid_q;
	logic [15:0] h;
	logic [7:0]  l;
	logic [15:0] l_adj;
	logic [15:0] code_full;
	logic [15:0] code_next;

	// Turn lead and trail into a JIS X 0208 linear index
	always_comb begin
		h = {8'h00, cmd.lead - ((cmd.lead < LeadSplit) ? LeadOffLo : LeadOffHi)};
		h = {h[14:0], 1'b0} + 16'd1;
		l = cmd.code;
		if (l >= TrailGap) begin
			l = l - 8'd1;
		end
		if (l >= TrailHigh) begin
			l = l - TrailSubH;
			h = h + 16'd1;
		end else begin
			l = l - TrailSubL;
		end
		l_adj     = {8'h00, l} - {8'h00, JisBase};
		code_full = 16'((h - {8'h00, JisBase}) * {9'd0, RowCells}) + l_adj;
		code_next = cmd.full_width ? code_full : {8'h00, cmd.code};
	end

	assign cmd_take = cmd_avail && (!out_valid_q || pop);
	assign empty    = !out_valid_q;

	// Hold the result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd_take) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the result payload
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			draw_x     <= cmd.draw_x;
			glyph_code <= code_next;
			full_width <= cmd.full_width;
		end
	end

endmodule

// File: rtl/sjis_glyph_stream_decoder.sv
// Shift-JIS glyph stream decoder: one draw command per decoded glyph.
// A glyph's command passes the command queue, then the result register.
// Throughput: one byte per cycle unless the queue is full; the back part drains
// one command per cycle while its result is empty or popped. Reset (arst_n low,
// asynchronous) clears config, lead state, queue count and result valid flag,
// and arms the cursor to load start_x on the next nonzero byte.
module sjis_glyph_stream_decoder import sgsd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	output logic         full,
	input  logic [7:0]   text_byte,
	output logic         empty,
	input  logic         pop,
	output logic signed [31:0] draw_x,
	output logic [15:0]  glyph_code,
	output logic         full_width,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	logic [1:0]  layer_q;
	logic [31:0] start_x_q;
	logic [31:0] row_y_q;
	logic [31:0] color_q;

	logic        acc;
	logic        cmd_valid;
	cmd_t        cmd_in;
	cmd_t        cmd_head;
	logic        cmd_nonempty;
	logic        cmd_take;
	logic        q_full;
	logic [31:0] draw_x_u;

	assign cfg_ready = 1'b1;
	assign full      = q_full;
	assign acc       = push && !q_full;
	assign draw_x    = draw_x_u;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layer_q   <= 2'd0;
			start_x_q <= 32'd0;
			row_y_q   <= 32'd0;
			color_q   <= 32'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_LAYER:   layer_q   <= cfg_data[1:0];
				CFG_START_X: start_x_q <= cfg_data;
				CFG_ROW_Y:   row_y_q   <= cfg_data;
				CFG_COLOR:   color_q   <= cfg_data;
				default:     layer_q   <= layer_q;
			endcase
		end
	end

	sgsd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.text_byte (text_byte),
		.start_x   (start_x_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd_in)
	);

	sgsd_cmd_fifo u_cmd_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cmd_valid),
		.wr_data  (cmd_in),
		.rd_en    (cmd_take),
		.rd_data  (cmd_head),
		.full     (q_full),
		.nonempty (cmd_nonempty)
	);

	sgsd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_avail  (cmd_nonempty),
		.cmd        (cmd_head),
		.cmd_take   (cmd_take),
		.pop        (pop),
		.empty      (empty),
		.draw_x     (draw_x_u),
		.glyph_code (glyph_code),
		.full_width (full_width)
	);

endmodule
